### hdl/gaussian_mean_shift_3d_assert.svh
// Assertion macros for the RTL of the mean shift block.
`ifndef GAUSSIAN_MEAN_SHIFT_3D_ASSERT_SVH
`define GAUSSIAN_MEAN_SHIFT_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define GMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/gms_pkg.sv
`default_nettype none
package gms_pkg;

    localparam int MAX_VOTES          = 64;
    localparam int KERNEL_TABLE_DEPTH = 256;
    localparam int ADDR_W = $clog2(MAX_VOTES);
    localparam int CNT_W  = $clog2(MAX_VOTES + 1);
    localparam int KIDX_W = $clog2(KERNEL_TABLE_DEPTH);
    localparam int SUM_W  = 16 + ADDR_W;
    localparam int WSUM_W = 16 + ADDR_W;
    localparam int WS_W   = 32 + ADDR_W;
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 31;
    localparam int DIV_SW = $clog2(DIV_NW + 1);

    localparam logic [1:0] CFG_BANDWIDTH = 2'd0;
    localparam logic [1:0] CFG_MAX_ITER  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    typedef enum logic [4:0] {
        ST_LOAD, ST_MSTART, ST_MWAIT, ST_PINIT, ST_RD, ST_SQ, ST_SQACC,
        ST_KIDX, ST_KWAIT, ST_WMUL, ST_WACC, ST_PSTART, ST_PWAIT,
        ST_MVMUL, ST_MVACC, ST_CHECK, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic short_mode;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    typedef logic [15:0] t_krom [KERNEL_TABLE_DEPTH];

    // exp(-i*16/DEPTH) in Q0.16, built from a Q30 Taylor series of the step ratio.
    function automatic t_krom build_krom();
        t_krom       rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] e;
        longint      sum;
        begin
            x = (64'd16 << 30) / KERNEL_TABLE_DEPTH;
            if (x > (64'd1 << 30)) x = 64'd1 << 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = ((term * x) >> 30) / 64'(k);
                if ((k % 2) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = 64'(sum);
            if (r > (64'd1 << 30)) r = 64'd1 << 30;
            p = 64'd1 << 30;
            for (int i = 0; i < KERNEL_TABLE_DEPTH; i++) begin
                if (i > 0) p = (p * r + (64'd1 << 29)) >> 30;
                e = (p + (64'd1 << 13)) >> 14;
                rom[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            end
            return rom;
        end
    endfunction

    localparam t_krom KROM = build_krom();

endpackage
`default_nettype wire

### hdl/gms_if.sv
`default_nettype none
interface gms_vote_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vote_x;
    logic signed [15:0] vote_y;
    logic signed [15:0] vote_z;
    logic               last_vote;
    modport source (output valid, vote_x, vote_y, vote_z, last_vote, input ready);
    modport sink (input valid, vote_x, vote_y, vote_z, last_vote, output ready);
endinterface

interface gms_mode_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mode_x;
    logic signed [15:0] mode_y;
    logic signed [15:0] mode_z;
    logic [5:0]         passes_used;
    logic               converged;
    logic               votes_dropped;
    modport source (output valid, mode_x, mode_y, mode_z, passes_used, converged,
                    votes_dropped, input ready);
    modport sink (input valid, mode_x, mode_y, mode_z, passes_used, converged,
                  votes_dropped, output ready);
endinterface

interface gms_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### hdl/gms_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The long form runs over the
// whole numerator; the short form assumes num < den and yields KIDX_W bits of
// floor(num * 2^KIDX_W / den).
module gms_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gms_pkg::t_div_req            i_req,
    input  wire logic [gms_pkg::DIV_NW-1:0]   i_num,
    input  wire logic [gms_pkg::DIV_DW-1:0]   i_den,
    output gms_pkg::t_div_rsp                 o_rsp,
    output logic [gms_pkg::DIV_NW-1:0]        o_quo
);
    logic                          r_busy;
    logic                          r_done;
    logic [gms_pkg::DIV_SW-1:0]    r_cnt;
    logic [gms_pkg::DIV_DW-1:0]    r_rem;
    logic [gms_pkg::DIV_NW-1:0]    r_sh;
    logic [gms_pkg::DIV_DW-1:0]    r_den;
    logic [gms_pkg::DIV_DW:0]      trial;
    logic                          ge;
    logic [gms_pkg::DIV_DW:0]      diff;

    assign trial = {r_rem, r_sh[gms_pkg::DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_den  <= i_den;
                if (i_req.short_mode) begin
                    r_rem <= i_num[gms_pkg::DIV_DW-1:0];
                    r_sh  <= '0;
                    r_cnt <= gms_pkg::DIV_SW'(gms_pkg::KIDX_W);
                end else begin
                    r_rem <= '0;
                    r_sh  <= i_num;
                    r_cnt <= gms_pkg::DIV_SW'(gms_pkg::DIV_NW);
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[gms_pkg::DIV_DW-1:0] : trial[gms_pkg::DIV_DW-1:0];
                r_sh  <= {r_sh[gms_pkg::DIV_NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == gms_pkg::DIV_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quo      = r_sh;
endmodule
`default_nettype wire

### hdl/gaussian_mean_shift_3d.sv
// Votes load at one per cycle while the block is in its load state; each set's
// result follows the last vote after P passes over the N stored votes. A vote inside
// the kernel takes a turn on the shared bit-serial divider; one outside skips it.
// Reset is synchronous, active low; it clears control, sums, count and mean.
// The vote memory has no reset: only entries written in the current set are read.
`default_nettype none
`include "gaussian_mean_shift_3d_assert.svh"
module gaussian_mean_shift_3d (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gms_vote_if.sink     i_vote,
    gms_cfg_if.sink      i_cfg,
    gms_mode_if.source   o_mode
);
    // Config registers: the user must write them only while idle; not enforced.
    logic [15:0] r_bw;
    logic [5:0]  r_maxit;
    logic [14:0] r_thr;

    // Derived constants, re-registered every cycle from the configuration.
    logic [gms_pkg::DIV_DW-1:0] r_kden;
    logic [29:0]                r_thr2;
    logic [5:0]                 r_limit;

    // The vote store holds {z, y, x} per entry; its registered read is ready in the next cycle.
    logic [47:0] mem [gms_pkg::MAX_VOTES];
    logic [47:0] r_rd;
    logic        mem_we;
    logic        mem_re;

    gms_pkg::t_state r_state, n_state;
    logic [gms_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                           r_ovf, n_ovf;
    logic signed [gms_pkg::SUM_W-1:0] r_sum [3];
    logic signed [gms_pkg::SUM_W-1:0] n_sum [3];
    logic signed [15:0]             r_mean [3];
    logic signed [15:0]             n_mean [3];
    logic signed [15:0]             r_nm [3];
    logic signed [15:0]             n_nm [3];
    logic signed [gms_pkg::WS_W-1:0] r_ws [3];
    logic signed [gms_pkg::WS_W-1:0] n_ws [3];
    logic [1:0]                     r_c, n_c;
    logic [gms_pkg::ADDR_W-1:0]     r_i, n_i;
    logic [32:0]                    r_sq, n_sq;
    logic [33:0]                    r_d2, n_d2;
    logic [33:0]                    r_move, n_move;
    logic [15:0]                    r_w, n_w;
    logic [gms_pkg::WSUM_W-1:0]     r_wsum, n_wsum;
    logic signed [31:0]             r_wp, n_wp;
    logic [5:0]                     r_pass, n_pass;
    logic                           r_neg, n_neg;

    // Output register: the next set loads while a result waits here.
    logic               r_ov, n_ov;
    logic signed [15:0] r_ox, r_oy, r_oz;
    logic [5:0]         r_opass;
    logic               r_oconv, r_odrop;
    logic               out_load;
    logic               conv_now;

    gms_pkg::t_div_req          div_req;
    gms_pkg::t_div_rsp          div_rsp;
    logic [gms_pkg::DIV_NW-1:0] div_num;
    logic [gms_pkg::DIV_DW-1:0] div_den;
    logic [gms_pkg::DIV_NW-1:0] div_quo;

    logic signed [15:0]         vote_c;
    logic signed [16:0]         dlt;
    logic signed [33:0]         sqr;
    logic [gms_pkg::SUM_W-1:0]  sum_mag;
    logic [gms_pkg::WS_W-1:0]   ws_mag;
    logic [gms_pkg::WSUM_W-1:0] wdiv;
    logic                       in_acc;
    logic                       last_idx;

    function automatic logic signed [15:0] sat16(input logic neg,
                                                 input logic [gms_pkg::DIV_NW-1:0] q);
        logic [15:0] nq;
        begin
            nq = 16'(~q[15:0] + 16'd1);
            if (neg) return (q > gms_pkg::DIV_NW'(32768)) ? 16'sh8000 : signed'(nq);
            return (q > gms_pkg::DIV_NW'(32767)) ? 16'sh7FFF : signed'(q[15:0]);
        end
    endfunction

    gms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_vote.ready = (r_state == gms_pkg::ST_LOAD);
    assign in_acc       = i_vote.valid && i_vote.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw    <= 16'd5243;
            r_maxit <= 6'd10;
            r_thr   <= 15'd410;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                gms_pkg::CFG_BANDWIDTH: r_bw    <= i_cfg.data;
                gms_pkg::CFG_MAX_ITER:  r_maxit <= i_cfg.data[5:0];
                gms_pkg::CFG_THRESHOLD: r_thr   <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // A zero bandwidth acts as one and a zero pass limit as one pass. The table
    // index is d2*DEPTH / (h << 15); it lands in the table only while d2 < h << 15.
    always_ff @(posedge i_clk) begin
        r_kden  <= {((r_bw == 16'd0) ? 16'd1 : r_bw), 15'd0};
        r_thr2  <= 30'(r_thr * r_thr);
        r_limit <= (r_maxit == 6'd0) ? 6'd1 : r_maxit;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_cnt[gms_pkg::ADDR_W-1:0]] <= {i_vote.vote_z, i_vote.vote_y,
                                                         i_vote.vote_x};
        if (mem_re) r_rd <= mem[r_i];
    end

    always_comb begin
        case (r_c)
            2'd0:    vote_c = signed'(r_rd[15:0]);
            2'd1:    vote_c = signed'(r_rd[31:16]);
            default: vote_c = signed'(r_rd[47:32]);
        endcase
    end

    always_comb begin
        if (r_state == gms_pkg::ST_MVMUL) dlt = {r_nm[r_c][15], r_nm[r_c]}
                                              - {r_mean[r_c][15], r_mean[r_c]};
        else dlt = {r_mean[r_c][15], r_mean[r_c]} - {vote_c[15], vote_c};
    end
    assign sqr      = dlt * dlt;
    assign sum_mag  = r_sum[r_c][gms_pkg::SUM_W-1] ? gms_pkg::SUM_W'(-r_sum[r_c])
                                                   : gms_pkg::SUM_W'(r_sum[r_c]);
    assign ws_mag   = r_ws[r_c][gms_pkg::WS_W-1] ? gms_pkg::WS_W'(-r_ws[r_c])
                                                 : gms_pkg::WS_W'(r_ws[r_c]);
    // Weight sums below one divide by one.
    assign wdiv     = (r_wsum > gms_pkg::WSUM_W'(65536)) ? r_wsum : gms_pkg::WSUM_W'(65536);
    assign last_idx = ({1'b0, r_i} == gms_pkg::CNT_W'(r_cnt - 1'b1));
    assign conv_now = (r_move < {4'd0, r_thr2});

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_sum    = r_sum;
        n_mean   = r_mean;
        n_nm     = r_nm;
        n_ws     = r_ws;
        n_c      = r_c;
        n_i      = r_i;
        n_sq     = r_sq;
        n_d2     = r_d2;
        n_move   = r_move;
        n_w      = r_w;
        n_wsum   = r_wsum;
        n_wp     = r_wp;
        n_pass   = r_pass;
        n_neg    = r_neg;
        n_ov     = r_ov;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        div_req  = '0;
        div_num  = '0;
        div_den  = '0;
        if (o_mode.ready) n_ov = 1'b0;

        case (r_state)
            gms_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < gms_pkg::CNT_W'(gms_pkg::MAX_VOTES)) begin
                        mem_we   = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                        n_sum[0] = r_sum[0] + gms_pkg::SUM_W'(i_vote.vote_x);
                        n_sum[1] = r_sum[1] + gms_pkg::SUM_W'(i_vote.vote_y);
                        n_sum[2] = r_sum[2] + gms_pkg::SUM_W'(i_vote.vote_z);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_vote.last_vote) begin
                        n_c     = 2'd0;
                        n_state = gms_pkg::ST_MSTART;
                    end
                end
            end
            // Start point: rounded plain average, one coordinate per division.
            gms_pkg::ST_MSTART: begin
                div_req.start = 1'b1;
                div_num = gms_pkg::DIV_NW'(sum_mag) + gms_pkg::DIV_NW'(r_cnt >> 1);
                div_den = (r_cnt == '0) ? gms_pkg::DIV_DW'(1) : gms_pkg::DIV_DW'(r_cnt);
                n_neg   = r_sum[r_c][gms_pkg::SUM_W-1];
                n_state = gms_pkg::ST_MWAIT;
            end
            gms_pkg::ST_MWAIT: begin
                if (div_rsp.done) begin
                    n_mean[r_c] = sat16(r_neg, div_quo);
                    if (r_c == 2'd2) begin
                        n_pass  = '0;
                        n_state = gms_pkg::ST_PINIT;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = gms_pkg::ST_MSTART;
                    end
                end
            end
            gms_pkg::ST_PINIT: begin
                n_ws    = '{default: '0};
                n_wsum  = '0;
                n_move  = '0;
                n_i     = '0;
                n_state = gms_pkg::ST_RD;
            end
            gms_pkg::ST_RD: begin
                mem_re  = 1'b1;
                n_c     = 2'd0;
                n_d2    = '0;
                n_state = gms_pkg::ST_SQ;
            end
            gms_pkg::ST_SQ: begin
                n_sq    = sqr[32:0];
                n_state = gms_pkg::ST_SQACC;
            end
            gms_pkg::ST_SQACC: begin
                n_d2 = r_d2 + 34'(r_sq);
                if (r_c == 2'd2) n_state = gms_pkg::ST_KIDX;
                else begin
                    n_c     = r_c + 1'b1;
                    n_state = gms_pkg::ST_SQ;
                end
            end
            // A vote outside the table range weighs nothing and is skipped.
            gms_pkg::ST_KIDX: begin
                if (r_d2 >= 34'(r_kden)) begin
                    if (last_idx) begin
                        n_c     = 2'd0;
                        n_state = gms_pkg::ST_PSTART;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = gms_pkg::ST_RD;
                    end
                end else begin
                    div_req.start      = 1'b1;
                    div_req.short_mode = 1'b1;
                    div_num = gms_pkg::DIV_NW'(r_d2);
                    div_den = r_kden;
                    n_state = gms_pkg::ST_KWAIT;
                end
            end
            gms_pkg::ST_KWAIT: begin
                if (div_rsp.done) begin
                    n_w     = gms_pkg::KROM[div_quo[gms_pkg::KIDX_W-1:0]];
                    n_wsum  = r_wsum + gms_pkg::WSUM_W'(gms_pkg::KROM[div_quo[gms_pkg::KIDX_W-1:0]]);
                    n_c     = 2'd0;
                    n_state = gms_pkg::ST_WMUL;
                end
            end
            gms_pkg::ST_WMUL: begin
                n_wp    = 32'(signed'({1'b0, r_w}) * vote_c);
                n_state = gms_pkg::ST_WACC;
            end
            gms_pkg::ST_WACC: begin
                n_ws[r_c] = r_ws[r_c] + gms_pkg::WS_W'(r_wp);
                if (r_c != 2'd2) begin
                    n_c     = r_c + 1'b1;
                    n_state = gms_pkg::ST_WMUL;
                end else if (last_idx) begin
                    n_c     = 2'd0;
                    n_state = gms_pkg::ST_PSTART;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = gms_pkg::ST_RD;
                end
            end
            gms_pkg::ST_PSTART: begin
                div_req.start = 1'b1;
                div_num = gms_pkg::DIV_NW'(ws_mag) + gms_pkg::DIV_NW'(wdiv >> 1);
                div_den = gms_pkg::DIV_DW'(wdiv);
                n_neg   = r_ws[r_c][gms_pkg::WS_W-1];
                n_state = gms_pkg::ST_PWAIT;
            end
            gms_pkg::ST_PWAIT: begin
                if (div_rsp.done) begin
                    n_nm[r_c] = sat16(r_neg, div_quo);
                    n_state   = gms_pkg::ST_MVMUL;
                end
            end
            gms_pkg::ST_MVMUL: begin
                n_sq    = sqr[32:0];
                n_state = gms_pkg::ST_MVACC;
            end
            gms_pkg::ST_MVACC: begin
                n_move = r_move + 34'(r_sq);
                if (r_c == 2'd2) n_state = gms_pkg::ST_CHECK;
                else begin
                    n_c     = r_c + 1'b1;
                    n_state = gms_pkg::ST_PSTART;
                end
            end
            // The move is measured against the old point before it is replaced.
            gms_pkg::ST_CHECK: begin
                n_mean = r_nm;
                n_pass = r_pass + 1'b1;
                if (conv_now || (r_pass + 1'b1 >= r_limit)) n_state = gms_pkg::ST_OUT;
                else n_state = gms_pkg::ST_PINIT;
            end
            gms_pkg::ST_OUT: begin
                if (!r_ov || o_mode.ready) begin
                    out_load = 1'b1;
                    n_ov     = 1'b1;
                    n_cnt    = '0;
                    n_sum    = '{default: '0};
                    n_ovf    = 1'b0;
                    n_state  = gms_pkg::ST_LOAD;
                end
            end
            default: n_state = gms_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gms_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sum   <= '{default: '0};
            r_mean  <= '{default: '0};
            r_c     <= '0;
            r_i     <= '0;
            r_pass  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_sum   <= n_sum;
            r_mean  <= n_mean;
            r_c     <= n_c;
            r_i     <= n_i;
            r_pass  <= n_pass;
            r_ov    <= n_ov;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_nm   <= n_nm;
        r_ws   <= n_ws;
        r_sq   <= n_sq;
        r_d2   <= n_d2;
        r_move <= n_move;
        r_w    <= n_w;
        r_wsum <= n_wsum;
        r_wp   <= n_wp;
        r_neg  <= n_neg;
        if (out_load) begin
            r_ox    <= r_mean[0];
            r_oy    <= r_mean[1];
            r_oz    <= r_mean[2];
            r_opass <= r_pass;
            r_oconv <= r_move < {4'd0, r_thr2};
            r_odrop <= r_ovf;
        end
    end

    assign o_mode.valid         = r_ov;
    assign o_mode.mode_x        = r_ox;
    assign o_mode.mode_y        = r_oy;
    assign o_mode.mode_z        = r_oz;
    assign o_mode.passes_used   = r_opass;
    assign o_mode.converged     = r_oconv;
    assign o_mode.votes_dropped = r_odrop;

    `GMS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= gms_pkg::CNT_W'(gms_pkg::MAX_VOTES))
    `GMS_ASSERT_IMP(a_div_free, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `GMS_ASSERT_NXT(a_out_clear, i_clk, i_rst_n, out_load, r_ov && (r_cnt == '0) && !r_ovf)
    `GMS_ASSERT_IMP(a_pass_nonzero, i_clk, i_rst_n, r_ov, r_opass != 6'd0)
endmodule
`default_nettype wire

### verif/tb_gaussian_mean_shift_3d.sv
`default_nettype none
module tb_gaussian_mean_shift_3d;

    // One expected mode estimate, in the widths of the result channel.
    typedef struct {
        logic signed [15:0] mode_x;
        logic signed [15:0] mode_y;
        logic signed [15:0] mode_z;
        logic [5:0]         passes_used;
        logic               converged;
        logic               votes_dropped;
    } mode_result_t;

    // Mean shift predictor plus the store of modes still owed by the block.
    class mode_scoreboard;
        logic [15:0]        bandwidth;
        logic [5:0]         iter_limit;
        logic [14:0]        threshold;
        logic [15:0]        kernel_rom [gms_pkg::KERNEL_TABLE_DEPTH];
        int                 votes [gms_pkg::MAX_VOTES][3];
        int                 stored;
        longint             sums [3];
        int                 mean [3];
        bit                 dropped;
        mode_result_t       owed [$];
        int                 mismatches;

        function new();
            longint unsigned x, term, r, p, e;
            longint          acc;
            x = (64'd16 << 30) / gms_pkg::KERNEL_TABLE_DEPTH;
            if (x > (64'd1 << 30)) x = 64'd1 << 30;
            term = 64'd1 << 30;
            acc = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = ((term * x) >> 30) / k;
                acc = (k % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            r = acc;
            if (r > (64'd1 << 30)) r = 64'd1 << 30;
            p = 64'd1 << 30;
            for (int i = 0; i < gms_pkg::KERNEL_TABLE_DEPTH; i++) begin
                if (i > 0) p = (p * r + (64'd1 << 29)) >> 30;
                e = (p + (64'd1 << 13)) >> 14;
                kernel_rom[i] = (e > 65535) ? 16'hFFFF : e[15:0];
            end
            bandwidth = 16'd5243;
            iter_limit = 6'd10;
            threshold = 15'd410;
            stored = 0;
            sums = '{0, 0, 0};
            mean = '{0, 0, 0};
            dropped = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                gms_pkg::CFG_BANDWIDTH: bandwidth = value;
                gms_pkg::CFG_MAX_ITER:  iter_limit = value[5:0];
                gms_pkg::CFG_THRESHOLD: threshold = value[14:0];
                default: ;
            endcase
        endfunction

        function int round_div(longint num, longint unsigned den);
            longint unsigned mag, q;
            mag = (num < 0) ? -num : num;
            if (den == 0) den = 1;
            q = (mag + den / 2) / den;
            if (num < 0) return (q > 32768) ? -32768 : -int'(q);
            return (q > 32767) ? 32767 : int'(q);
        endfunction

        function longint gauss_weight(longint unsigned d2);
            longint unsigned h, idx;
            h = (bandwidth != 0) ? bandwidth : 1;
            idx = d2 * gms_pkg::KERNEL_TABLE_DEPTH / (h << 15);
            if (idx >= gms_pkg::KERNEL_TABLE_DEPTH) return 0;
            return kernel_rom[idx];
        endfunction

        // Notes one accepted vote; the flagged last vote runs the mode search.
        function void note_vote(logic signed [15:0] vx, logic signed [15:0] vy,
                                logic signed [15:0] vz, logic last);
            int              lim, pass, nm;
            bit              conv;
            longint          ws [3];
            longint          wsum, w, d;
            longint unsigned d2, move2, thr2, dv;
            mode_result_t    res;
            if (stored < gms_pkg::MAX_VOTES) begin
                votes[stored] = '{vx, vy, vz};
                for (int c = 0; c < 3; c++) sums[c] += votes[stored][c];
                stored++;
            end else begin
                dropped = 1;
            end
            if (!last) return;
            for (int c = 0; c < 3; c++) mean[c] = round_div(sums[c], (stored != 0) ? stored : 1);
            lim = (iter_limit != 0) ? iter_limit : 1;
            thr2 = longint'(threshold) * threshold;
            pass = 0;
            conv = 0;
            while (pass < lim) begin
                ws = '{0, 0, 0};
                wsum = 0;
                for (int i = 0; i < stored; i++) begin
                    d2 = 0;
                    for (int c = 0; c < 3; c++) begin
                        d = mean[c] - votes[i][c];
                        d2 += d * d;
                    end
                    w = gauss_weight(d2);
                    wsum += w;
                    for (int c = 0; c < 3; c++) ws[c] += w * votes[i][c];
                end
                dv = (wsum > 65536) ? wsum : 65536;
                move2 = 0;
                for (int c = 0; c < 3; c++) begin
                    nm = round_div(ws[c], dv);
                    d = nm - mean[c];
                    move2 += d * d;
                    mean[c] = nm;
                end
                pass++;
                if (move2 < thr2) begin
                    conv = 1;
                    break;
                end
            end
            res.mode_x = 16'(mean[0]);
            res.mode_y = 16'(mean[1]);
            res.mode_z = 16'(mean[2]);
            res.passes_used = 6'(pass);
            res.converged = conv;
            res.votes_dropped = dropped;
            owed = {owed, res};
            stored = 0;
            sums = '{0, 0, 0};
            dropped = 0;
        endfunction

        function void check_mode(mode_result_t got);
            mode_result_t want;
            if (owed.size() == 0) begin
                $error("mode result arrived with none expected");
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (got.mode_x !== want.mode_x) begin
                $error("mode_x: expected %0d, got %0d", want.mode_x, got.mode_x);
                mismatches++;
            end
            if (got.mode_y !== want.mode_y) begin
                $error("mode_y: expected %0d, got %0d", want.mode_y, got.mode_y);
                mismatches++;
            end
            if (got.mode_z !== want.mode_z) begin
                $error("mode_z: expected %0d, got %0d", want.mode_z, got.mode_z);
                mismatches++;
            end
            if (got.passes_used !== want.passes_used) begin
                $error("passes_used: expected %0d, got %0d", want.passes_used,
                       got.passes_used);
                mismatches++;
            end
            if (got.converged !== want.converged) begin
                $error("converged: expected %0b, got %0b", want.converged, got.converged);
                mismatches++;
            end
            if (got.votes_dropped !== want.votes_dropped) begin
                $error("votes_dropped: expected %0b, got %0b", want.votes_dropped,
                       got.votes_dropped);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gms_vote_if vote_ch ();
    gms_cfg_if  cfg_ch ();
    gms_mode_if mode_ch ();

    gaussian_mean_shift_3d u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vote  (vote_ch),
        .i_cfg   (cfg_ch),
        .o_mode  (mode_ch)
    );

    mode_scoreboard modes;
    // When set, both sides run without any idle cycles.
    bit             no_gaps;
    int             sink_stall;

    initial modes = new();

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // The receiver stalls at random so stalls land in every state of the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_ch.ready <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall > 0) begin
            mode_ch.ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            mode_ch.ready <= 1'b1;
            sink_stall <= pick_gap();
        end
    end

    // Every accepted mode is compared against the oldest prediction.
    always @(posedge i_clk) begin
        mode_result_t got;
        if (i_rst_n && mode_ch.valid && mode_ch.ready) begin
            got.mode_x = mode_ch.mode_x;
            got.mode_y = mode_ch.mode_y;
            got.mode_z = mode_ch.mode_z;
            got.passes_used = mode_ch.passes_used;
            got.converged = mode_ch.converged;
            got.votes_dropped = mode_ch.votes_dropped;
            modes.check_mode(got);
        end
    end

    // A vote request stays up until the block takes it; valid is only lowered
    // when a gap follows, so back-to-back votes keep it high.
    task automatic send_vote(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] vz, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            vote_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vote_ch.valid <= 1'b1;
        vote_ch.vote_x <= vx;
        vote_ch.vote_y <= vy;
        vote_ch.vote_z <= vz;
        vote_ch.last_vote <= last;
        do @(posedge i_clk); while (!vote_ch.ready);
        modes.note_vote(vx, vy, vz, last);
    endtask

    // Valid is lowered after each write, so it drops between writes.
    task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        modes.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Registers change only once every owed mode is out and the block is quiet.
    task automatic drain();
        vote_ch.valid <= 1'b0;
        while (modes.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // A well-formed set: votes clustered around a random center, the spread
    // scaled so that some land inside the kernel and some outside.
    task automatic send_cluster(int count, int spread);
        int cx, cy, cz;
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        cz = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Stray vote anywhere in the field range.
                send_vote(16'($urandom), 16'($urandom), 16'($urandom), i == count - 1);
            end else begin
                send_vote(16'(cx + int'($urandom_range(0, 2 * spread)) - spread),
                          16'(cy + int'($urandom_range(0, 2 * spread)) - spread),
                          16'(cz + int'($urandom_range(0, 2 * spread)) - spread),
                          i == count - 1);
            end
        end
    endtask

    initial begin
        int set_len;
        i_rst_n <= 1'b0;
        vote_ch.valid <= 1'b0;
        vote_ch.vote_x <= '0;
        vote_ch.vote_y <= '0;
        vote_ch.vote_z <= '0;
        vote_ch.last_vote <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.addr <= gms_pkg::CFG_BANDWIDTH;
        cfg_ch.data <= '0;
        no_gaps = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets under the reset settings: a lone vote, field extremes,
        // and votes all sitting on one point.
        send_vote(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
        send_vote(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_vote(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_vote(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vote(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_vote(16'sh0100, -16'sh0100, 16'sh0010, 1'b0);
        send_vote(16'sh0100, -16'sh0100, 16'sh0010, 1'b0);
        send_vote(16'sh0100, -16'sh0100, 16'sh0010, 1'b1);
        // Votes far apart: every weight falls outside the kernel, so the weight
        // sum is below one and the point shrinks toward zero.
        send_vote(16'sh7000, 16'sh7000, 16'sh7000, 1'b0);
        send_vote(-16'sh7000, 16'sh7000, 16'sh7000, 1'b0);
        send_vote(16'sh0000, -16'sh7000, 16'sh5000, 1'b1);
        drain();

        // Zero bandwidth and zero pass limit are both treated as one; the
        // unused register index must be ignored.
        write_cfg(gms_pkg::CFG_BANDWIDTH, 16'd0);
        write_cfg(gms_pkg::CFG_MAX_ITER, 16'd0);
        write_cfg(gms_pkg::CFG_THRESHOLD, 16'd0);
        write_cfg(2'd3, 16'hFFFF);
        send_cluster(4, 40);
        drain();

        // Overflowing store: the set ends with a dropped last vote.
        write_cfg(gms_pkg::CFG_BANDWIDTH, 16'hFFFF);
        write_cfg(gms_pkg::CFG_MAX_ITER, 16'd3);
        write_cfg(gms_pkg::CFG_THRESHOLD, 16'h7FFF);
        send_cluster(gms_pkg::MAX_VOTES + 5, 3000);
        drain();

        // Pass limit at its top with a threshold of zero so no early stop.
        write_cfg(gms_pkg::CFG_BANDWIDTH, 16'd1);
        write_cfg(gms_pkg::CFG_MAX_ITER, 16'd63);
        write_cfg(gms_pkg::CFG_THRESHOLD, 16'd0);
        send_cluster(3, 4);
        drain();

        // Random phases, each with its own settings.
        for (int phase = 0; phase < 8; phase++) begin
            int sent;
            no_gaps = (phase % 4 == 3);
            case ($urandom_range(0, 3))
                0: write_cfg(gms_pkg::CFG_BANDWIDTH, 16'd1);
                1: write_cfg(gms_pkg::CFG_BANDWIDTH, 16'hFFFF);
                default: write_cfg(gms_pkg::CFG_BANDWIDTH, 16'($urandom_range(1000, 30000)));
            endcase
            case ($urandom_range(0, 3))
                0: write_cfg(gms_pkg::CFG_MAX_ITER, 16'd1);
                1: write_cfg(gms_pkg::CFG_MAX_ITER, 16'd63);
                default: write_cfg(gms_pkg::CFG_MAX_ITER, 16'($urandom_range(2, 12)));
            endcase
            case ($urandom_range(0, 3))
                0: write_cfg(gms_pkg::CFG_THRESHOLD, 16'd0);
                1: write_cfg(gms_pkg::CFG_THRESHOLD, 16'h7FFF);
                default: write_cfg(gms_pkg::CFG_THRESHOLD, 16'($urandom_range(50, 2000)));
            endcase
            sent = 0;
            while (sent < 210) begin
                // Mostly small sets; a nearly full, full or overflowing store only
                // now and then, and only when the pass limit keeps it affordable.
                if (modes.iter_limit <= 12 && $urandom_range(0, 29) == 0)
                    set_len = $urandom_range(gms_pkg::MAX_VOTES - 2, gms_pkg::MAX_VOTES + 6);
                else
                    set_len = $urandom_range(1, 12);
                send_cluster(set_len, (1 << $urandom_range(2, 14)));
                sent += set_len;
            end
            drain();
        end

        if (modes.mismatches == 0 && modes.owed.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1000000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

### gaussian_mean_shift_3d.f
+incdir+hdl
hdl/gms_pkg.sv
hdl/gms_if.sv
hdl/gms_div.sv
hdl/gaussian_mean_shift_3d.sv
verif/tb_gaussian_mean_shift_3d.sv
